// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold at every clock edge out of reset.
`define NVLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that implies a consequence in the same cycle.
`define NVLT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/nvlt_pkg.sv =====
// Types, constants and helper functions of the nominal value list tokenizer.
`timescale 1ns / 1ps

package nvlt_pkg;

	// Depth of the interior whitespace store and the widths that follow from it.
	localparam int HOLD_DEPTH = 16;
	localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
	localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

	typedef logic [CNT_W-1:0] hold_cnt_t;
	typedef logic [IDX_W-1:0] hold_idx_t;

	// Characters the parser reacts to.
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Parse phases.
	typedef enum logic [2:0] {
		PH_WAIT,
		PH_BEFORE,
		PH_WORD,
		PH_AFTER,
		PH_QUOTE,
		PH_ESC,
		PH_DONE,
		PH_FAULT
	} phase_t;

	// Status codes reported with every result.
	typedef enum logic [2:0] {
		STAT_RUNNING,
		STAT_COMPLETE,
		STAT_NO_BRACE,
		STAT_BAD_SEP,
		STAT_INCOMPLETE,
		STAT_OVERFLOW
	} status_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} ctrl_state_t;

	// Payload of one input beat.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       new_set;
		logic       final_byte;
	} text_beat_t;

	// Payload of one result beat.
	typedef struct packed {
		logic [7:0] name_byte;
		logic       byte_present;
		logic       name_end;
		logic [2:0] status;
		logic       last_of_run;
	} name_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic out_busy;
		logic flush_needed;
		logic flush_last;
	} dp_stat_t;

	// Space, tab, newline, vertical tab, form feed and carriage return.
	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

// ===== hw/rtl/nvlt_text_if.sv =====
// Input channel carrying one byte of list text per beat.
`timescale 1ns / 1ps

interface nvlt_text_if import nvlt_pkg::*; ();
	logic       valid;
	logic       ready;
	text_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nvlt_name_if.sv =====
// Output channel carrying one result of the tokenizer per beat.
`timescale 1ns / 1ps

interface nvlt_name_if import nvlt_pkg::*; ();
	logic       valid;
	logic       ready;
	name_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nominal_value_list_tokenizer.sv =====
// A result is registered: it is offered in the cycle after its byte is taken.
// Throughput: one byte per cycle while results are taken; a byte that ends held
// interior whitespace gives held count + 1 results before the next byte is taken.
// Reset (arst_n, asynchronous): parse waits for the opening brace, held count
// is zero and the output register is empty; the whitespace store is not cleared.
`timescale 1ns / 1ps

module nominal_value_list_tokenizer import nvlt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nvlt_text_if.sink   text_ch,
	nvlt_name_if.source name_ch
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic       text_ready;
	logic       out_valid;
	name_beat_t out_beat;

	// Sequencing of byte intake and flush beats.
	nvlt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_ch.valid),
		.text_ready (text_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Parse logic, whitespace store and output register.
	nvlt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (text_ch.data),
		.out_ready (name_ch.ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_beat  (out_beat)
	);

	assign text_ch.ready = text_ready;
	assign name_ch.valid = out_valid;
	assign name_ch.data  = out_beat;

endmodule

// ===== hw/rtl/nvlt_datapath.sv =====
// Parse state, whitespace store and output register of the tokenizer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nvlt_datapath import nvlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  text_beat_t beat,
	input  logic       out_ready,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       out_valid,
	output name_beat_t out_beat
);

	phase_t     phase_q;
	status_t    fault_q;
	hold_cnt_t  held_count_q;
	logic [7:0] held_q [HOLD_DEPTH];
	hold_cnt_t  flush_len_q;
	hold_cnt_t  flush_idx_q;
	logic [7:0] pend_byte_q;
	status_t    pend_stat_q;
	logic       out_valid_q;
	name_beat_t out_q;

	phase_t     ph0, ph_n;
	status_t    fc0, fc_n, stat_n;
	hold_cnt_t  hc0, hc_n;
	logic [7:0] b;
	logic       blank;
	logic       hold_wr;
	logic       emit_byte;
	logic       emit_end;
	logic       flush;

	// One parse step for the byte on the input channel.
	always_comb begin
		b         = beat.text_byte;
		blank     = is_blank(b);
		ph0       = beat.new_set ? PH_WAIT : phase_q;
		hc0       = beat.new_set ? '0 : held_count_q;
		fc0       = beat.new_set ? STAT_RUNNING : fault_q;
		ph_n      = ph0;
		hc_n      = hc0;
		fc_n      = fc0;
		hold_wr   = 1'b0;
		emit_byte = 1'b0;
		emit_end  = 1'b0;
		flush     = 1'b0;
		unique case (ph0)
			PH_WAIT: begin
				if (b == CH_LBRACE) begin
					ph_n = PH_BEFORE;
				end else if (!blank) begin
					ph_n = PH_FAULT;
					fc_n = STAT_NO_BRACE;
					hc_n = '0;
				end
			end
			PH_BEFORE: begin
				if (b == CH_COMMA) begin
					emit_end = 1'b1;
				end else if (b == CH_QUOTE) begin
					ph_n = PH_QUOTE;
				end else if (!blank) begin
					ph_n      = PH_WORD;
					hc_n      = '0;
					emit_byte = 1'b1;
				end
			end
			PH_WORD: begin
				if ((b == CH_RBRACE) || (b == CH_COMMA)) begin
					hc_n     = '0;
					emit_end = 1'b1;
					ph_n     = (b == CH_RBRACE) ? PH_DONE : PH_BEFORE;
				end else if (blank) begin
					if (hc0 >= CNT_W'(HOLD_DEPTH)) begin
						ph_n = PH_FAULT;
						fc_n = STAT_OVERFLOW;
						hc_n = '0;
					end else begin
						hold_wr = 1'b1;
						hc_n    = hc0 + 1'b1;
					end
				end else begin
					flush     = (hc0 != '0);
					hc_n      = '0;
					emit_byte = 1'b1;
				end
			end
			PH_AFTER: begin
				if (b == CH_COMMA) begin
					ph_n = PH_BEFORE;
				end else if (b == CH_RBRACE) begin
					ph_n = PH_DONE;
				end else if (!blank) begin
					ph_n = PH_FAULT;
					fc_n = STAT_BAD_SEP;
					hc_n = '0;
				end
			end
			PH_QUOTE: begin
				if (b == CH_QUOTE) begin
					emit_end = 1'b1;
					ph_n     = PH_AFTER;
				end else begin
					if (b == CH_BSLASH) begin
						ph_n = PH_ESC;
					end
					emit_byte = 1'b1;
				end
			end
			PH_ESC: begin
				emit_byte = 1'b1;
				ph_n      = PH_QUOTE;
			end
			default: begin
			end
		endcase

		// The text ended before the list was closed.
		if (beat.final_byte && (ph_n != PH_DONE) && (ph_n != PH_FAULT)) begin
			ph_n = PH_FAULT;
			fc_n = STAT_INCOMPLETE;
			hc_n = '0;
		end

		if (ph_n == PH_DONE) begin
			stat_n = STAT_COMPLETE;
		end else if (ph_n == PH_FAULT) begin
			stat_n = fc_n;
		end else begin
			stat_n = STAT_RUNNING;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			fault_q      <= STAT_RUNNING;
			held_count_q <= '0;
			flush_len_q  <= '0;
			flush_idx_q  <= '0;
		end else if (cmd.step) begin
			phase_q      <= ph_n;
			fault_q      <= fc_n;
			held_count_q <= hc_n;
			if (flush) begin
				flush_len_q <= hc0;
				flush_idx_q <= CNT_W'(1);
			end
		end else if (cmd.emit && (flush_idx_q != flush_len_q)) begin
			flush_idx_q <= flush_idx_q + 1'b1;
		end
	end

	// Whitespace store and the byte that waits behind a flush.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pend_byte_q <= b;
			pend_stat_q <= stat_n;
			if (hold_wr) begin
				held_q[hc0[IDX_W-1:0]] <= b;
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload of the beat on offer.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_q.name_byte    <= flush ? held_q[0] : (emit_byte ? b : 8'h00);
			out_q.byte_present <= flush || emit_byte;
			out_q.name_end     <= emit_end;
			out_q.status       <= stat_n;
			out_q.last_of_run  <= !flush;
		end else if (cmd.emit) begin
			out_q.byte_present <= 1'b1;
			out_q.name_end     <= 1'b0;
			out_q.status       <= pend_stat_q;
			if (flush_idx_q == flush_len_q) begin
				out_q.name_byte   <= pend_byte_q;
				out_q.last_of_run <= 1'b1;
			end else begin
				out_q.name_byte   <= held_q[flush_idx_q[IDX_W-1:0]];
				out_q.last_of_run <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_beat           = out_q;
	assign stat.out_free      = !out_valid_q || out_ready;
	assign stat.out_busy      = out_valid_q;
	assign stat.flush_needed  = flush;
	assign stat.flush_last    = (flush_idx_q == flush_len_q);

	`NVLT_ASSERT(a_held_bound, held_count_q <= CNT_W'(HOLD_DEPTH), "held count beyond store depth")
	`NVLT_ASSERT_IMPL(a_held_in_word, held_count_q != '0, phase_q == PH_WORD, "spaces held outside a name")
	`NVLT_ASSERT(a_flush_bound, flush_idx_q <= flush_len_q, "flush index past flush length")

endmodule

// ===== hw/rtl/nvlt_ctrl.sv =====
// Controller of the tokenizer: takes bytes and sequences whitespace flushes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nvlt_ctrl import nvlt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     text_valid,
	output logic     text_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		text_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				text_ready = stat.out_free;
				if (text_valid && stat.out_free) begin
					cmd.step = 1'b1;
					if (stat.flush_needed) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.flush_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`NVLT_ASSERT_IMPL(a_flush_has_beat, state_q == ST_FLUSH, stat.out_busy, "flush without a beat on offer")

endmodule

// ===== tb/nvlt_name_checker.sv =====
// Tokenizer checker: predicts name results from accepted text beats and compares them.
`timescale 1ns / 1ps

module nvlt_name_checker import nvlt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	nvlt_text_if  text_ch,
	nvlt_name_if  name_ch,
	output int    errors,
	output int    pending,
	output int    checked
);

	// Shadow copy of the parser state.
	phase_t     phase;
	status_t    fault;
	logic [7:0] held [HOLD_DEPTH];
	int         held_cnt;

	name_beat_t expected_names [$];
	name_beat_t step_names [$];

	// Space, tab, newline, vertical tab, form feed and carriage return.
	function automatic bit is_space(input logic [7:0] b);
		case (b)
			8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_name(input logic [7:0] b, input logic present,
			input logic last);
		name_beat_t r;
		r.name_byte    = present ? b : 8'h00;
		r.byte_present = present;
		r.name_end     = last;
		r.status       = STAT_RUNNING;
		r.last_of_run  = 1'b0;
		step_names.insert(step_names.size(), r);
	endfunction

	function automatic void enter_fault(input status_t code);
		phase    = PH_FAULT;
		fault    = code;
		held_cnt = 0;
	endfunction

	// Work out the results of one text beat and queue them.
	function automatic void tokenize_beat(input text_beat_t beat);
		logic [7:0] b;
		status_t    st;
		b = beat.text_byte;
		step_names.delete();
		if (beat.new_set) begin
			phase    = PH_WAIT;
			held_cnt = 0;
			fault    = STAT_RUNNING;
		end
		case (phase)
			PH_WAIT: begin
				if (b == CH_LBRACE)
					phase = PH_BEFORE;
				else if (!is_space(b))
					enter_fault(STAT_NO_BRACE);
			end
			PH_BEFORE: begin
				if (b == CH_COMMA) begin
					add_name(8'h00, 1'b0, 1'b1);
				end else if (b == CH_QUOTE) begin
					phase = PH_QUOTE;
				end else if (!is_space(b)) begin
					phase    = PH_WORD;
					held_cnt = 0;
					add_name(b, 1'b1, 1'b0);
				end
			end
			PH_WORD: begin
				if (b == CH_RBRACE || b == CH_COMMA) begin
					held_cnt = 0;
					add_name(8'h00, 1'b0, 1'b1);
					phase = (b == CH_RBRACE) ? PH_DONE : PH_BEFORE;
				end else if (is_space(b)) begin
					if (held_cnt >= HOLD_DEPTH)
						enter_fault(STAT_OVERFLOW);
					else begin
						held[held_cnt] = b;
						held_cnt++;
					end
				end else begin
					// Held interior whitespace goes out ahead of the byte.
					for (int i = 0; i < held_cnt; i++)
						add_name(held[i], 1'b1, 1'b0);
					held_cnt = 0;
					add_name(b, 1'b1, 1'b0);
				end
			end
			PH_AFTER: begin
				if (b == CH_COMMA)
					phase = PH_BEFORE;
				else if (b == CH_RBRACE)
					phase = PH_DONE;
				else if (!is_space(b))
					enter_fault(STAT_BAD_SEP);
			end
			PH_QUOTE: begin
				if (b == CH_QUOTE) begin
					add_name(8'h00, 1'b0, 1'b1);
					phase = PH_AFTER;
				end else begin
					if (b == CH_BSLASH)
						phase = PH_ESC;
					add_name(b, 1'b1, 1'b0);
				end
			end
			PH_ESC: begin
				add_name(b, 1'b1, 1'b0);
				phase = PH_QUOTE;
			end
			default: ;
		endcase

		// A text that ends before the closing brace is incomplete.
		if (beat.final_byte && phase != PH_DONE && phase != PH_FAULT)
			enter_fault(STAT_INCOMPLETE);

		if (step_names.size() == 0)
			add_name(8'h00, 1'b0, 1'b0);

		if (phase == PH_DONE)
			st = STAT_COMPLETE;
		else if (phase == PH_FAULT)
			st = fault;
		else
			st = STAT_RUNNING;

		foreach (step_names[i]) begin
			step_names[i].status = st;
			step_names[i].last_of_run = (i == step_names.size() - 1);
			expected_names.insert(expected_names.size(), step_names[i]);
		end
	endfunction

	// Predict on every accepted text beat, compare every accepted name beat.
	always @(posedge clk or negedge arst_n) begin
		name_beat_t want;
		name_beat_t got;
		if (!arst_n) begin
			phase    = PH_WAIT;
			fault    = STAT_RUNNING;
			held_cnt = 0;
			errors   <= 0;
			checked  <= 0;
			pending  <= 0;
			expected_names.delete();
		end else begin
			if (text_ch.valid && text_ch.ready)
				tokenize_beat(text_ch.data);
			if (name_ch.valid && name_ch.ready) begin
				got = name_ch.data;
				checked <= checked + 1;
				if (expected_names.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("[%0t] unexpected name beat: byte %02h present %0b end %0b status %0d last %0b",
							$realtime, got.name_byte, got.byte_present, got.name_end,
							got.status, got.last_of_run);
				end else begin
					want = expected_names.pop_front();
					if (got.name_byte !== want.name_byte ||
							got.byte_present !== want.byte_present ||
							got.name_end !== want.name_end ||
							got.status !== want.status ||
							got.last_of_run !== want.last_of_run) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("[%0t] name beat mismatch:", $realtime);
							$display("  expected byte %02h present %0b end %0b status %0d last %0b",
								want.name_byte, want.byte_present, want.name_end,
								want.status, want.last_of_run);
							$display("  actual   byte %02h present %0b end %0b status %0d last %0b",
								got.name_byte, got.byte_present, got.name_end,
								got.status, got.last_of_run);
						end
					end
				end
			end
			pending <= expected_names.size();
		end
	end

endmodule

// ===== tb/nominal_value_list_tokenizer_test.sv =====
// Testbench top: drives list text into the tokenizer under varied pacing and gives the verdict.
`timescale 1ns / 1ps

module nominal_value_list_tokenizer_test;
	import nvlt_pkg::*;

	localparam int PHASE_BYTES = 100;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   sent;
	int   lists;
	int   errors;
	int   pending;
	int   checked;

	text_beat_t list_q [$];

	nvlt_text_if text_ch ();
	nvlt_name_if name_ch ();

	nominal_value_list_tokenizer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_ch (text_ch),
		.name_ch (name_ch)
	);

	nvlt_name_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_ch (text_ch),
		.name_ch (name_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up after a generous fixed time.
	initial begin
		#5_000_000;
		$display("nominal_value_list_tokenizer_test: FAIL");
		$finish;
	end

	// Result side: stall at random, at the rate of the current phase.
	initial begin
		name_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			name_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one text beat and hold it until it is taken. Called at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic ns, input logic fin);
		text_beat_t beat;
		beat.text_byte  = b;
		beat.new_set    = ns;
		beat.final_byte = fin;
		while ($urandom_range(99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data  <= beat;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain();
		text_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic void push_byte(input logic [7:0] b);
		text_beat_t beat;
		beat.text_byte  = b;
		beat.new_set    = 1'b0;
		beat.final_byte = 1'b0;
		list_q.insert(list_q.size(), beat);
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] blanks [6];
		blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		return blanks[$urandom_range(5)];
	endfunction

	function automatic void push_blanks(input int n);
		for (int i = 0; i < n; i++)
			push_byte(blank_byte());
	endfunction

	// A byte that keeps an unquoted name going; a quote may not open one.
	function automatic logic [7:0] word_byte(input bit first);
		logic [7:0] b;
		do begin
			if ($urandom_range(3) == 0)
				b = 8'($urandom_range(8));
			else
				b = 8'($urandom_range(14, 255));
		end while (b == CH_COMMA || b == CH_RBRACE || b == CH_SPACE ||
			(first && b == CH_QUOTE));
		return b;
	endfunction

	// Unquoted name with interior whitespace runs; now and then a full or overfull run.
	function automatic void push_word();
		int run;
		push_byte(word_byte(1'b1));
		repeat ($urandom_range(3)) begin
			case ($urandom_range(19))
				0: run = HOLD_DEPTH;
				1: run = HOLD_DEPTH + 1;
				default: run = $urandom_range(3);
			endcase
			push_blanks(run);
			repeat ($urandom_range(1, 3))
				push_byte(word_byte(1'b0));
		end
		push_blanks($urandom_range(2));
	endfunction

	// Quoted name with raw content and backslash escapes.
	function automatic void push_quoted();
		logic [7:0] b;
		push_byte(CH_QUOTE);
		repeat ($urandom_range(5)) begin
			if ($urandom_range(4) == 0) begin
				push_byte(CH_BSLASH);
				push_byte(8'($urandom_range(255)));
			end else begin
				do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
				push_byte(b);
			end
		end
		push_byte(CH_QUOTE);
		push_blanks($urandom_range(2));
	endfunction

	// Build one list, mostly well formed, sometimes broken or pure noise.
	function automatic void build_list();
		int   names;
		logic [7:0] specials [7];
		specials = '{CH_LBRACE, CH_COMMA, CH_RBRACE, CH_QUOTE, CH_BSLASH, CH_SPACE, CH_TAB};
		list_q.delete();
		if ($urandom_range(99) < 85) begin
			push_blanks($urandom_range(2));
			push_byte(CH_LBRACE);
			names = $urandom_range(4);
			for (int i = 0; i < names; i++) begin
				push_blanks($urandom_range(2));
				case ($urandom_range(3))
					0: ;
					1, 2: push_word();
					default: push_quoted();
				endcase
				if (i != names - 1)
					push_byte(CH_COMMA);
			end
			if ($urandom_range(9) != 0)
				push_byte(CH_RBRACE);
			repeat ($urandom_range(2))
				push_byte(8'($urandom_range(255)));
			// Broken variants: a byte overwritten, or the text cut short.
			if ($urandom_range(6) == 0)
				list_q[$urandom_range(list_q.size() - 1)].text_byte = 8'($urandom_range(255));
			if ($urandom_range(9) == 0)
				while (list_q.size() > 1 && $urandom_range(3) != 0)
					void'(list_q.pop_back());
			list_q[0].new_set = 1'b1;
			list_q[list_q.size() - 1].final_byte = 1'($urandom_range(1));
		end else begin
			repeat ($urandom_range(3, 10)) begin
				if ($urandom_range(1) == 0)
					push_byte(8'($urandom_range(255)));
				else
					push_byte(specials[$urandom_range(6)]);
				list_q[list_q.size() - 1].new_set    = ($urandom_range(7) == 0);
				list_q[list_q.size() - 1].final_byte = ($urandom_range(9) == 0);
			end
			list_q[0].new_set = 1'($urandom_range(1));
		end
	endfunction

	// Stimulus and verdict.
	initial begin
		int pacing_idle [4];
		int pacing_stall [4];
		int target;
		int waited;
		pacing_idle  = '{0, 48, 0, 9};
		pacing_stall = '{0, 0, 48, 9};
		arst_n        = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.data  = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		sent          = 0;
		lists         = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty name, quoted name with escaped quote, extreme bytes,
		// interior whitespace flush, trailing whitespace, ignored bytes after
		// the list, brace opening a name, incomplete text, missing brace,
		// bad separator.
		send_byte(CH_SPACE, 1'b1, 1'b0);
		send_byte(CH_LBRACE, 1'b0, 1'b0);
		send_byte(CH_COMMA, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(CH_BSLASH, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b0);
		send_byte(CH_SPACE, 1'b0, 1'b0);
		send_byte(CH_COMMA, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(CH_TAB, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(CH_SPACE, 1'b0, 1'b0);
		send_byte(CH_RBRACE, 1'b0, 1'b0);
		send_byte("q", 1'b0, 1'b0);
		send_byte(CH_LBRACE, 1'b1, 1'b0);
		send_byte(CH_RBRACE, 1'b0, 1'b0);
		send_byte("z", 1'b0, 1'b1);
		send_byte("x", 1'b0, 1'b0);
		send_byte("x", 1'b1, 1'b0);
		send_byte(CH_LBRACE, 1'b1, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b0);
		send_byte("k", 1'b0, 1'b0);
		drain();

		// Random lists under each pacing, with a full drain between phases.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = pacing_idle[ph];
			stall_pct = pacing_stall[ph];
			target    = sent + PHASE_BYTES;
			while (sent < target) begin
				build_list();
				foreach (list_q[i])
					send_byte(list_q[i].text_byte, list_q[i].new_set, list_q[i].final_byte);
				lists++;
			end
			drain();
		end

		// Let any stray result show up before the verdict.
		stall_pct = 0;
		waited = 0;
		while (pending != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);

		$display("Sent %0d text bytes (%0d random lists plus a directed set) and checked %0d results",
			sent, lists, checked);
		$display("under four pacing phases: free flow, sender gaps, result stalls, and both.");
		if (errors == 0 && pending == 0) begin
			$display("nominal_value_list_tokenizer_test: PASS");
		end else begin
			$display("nominal_value_list_tokenizer_test: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/nvlt_pkg.sv
hw/rtl/nvlt_text_if.sv
hw/rtl/nvlt_name_if.sv
hw/rtl/nvlt_datapath.sv
hw/rtl/nvlt_ctrl.sv
hw/rtl/nominal_value_list_tokenizer.sv
tb/nvlt_name_checker.sv
tb/nominal_value_list_tokenizer_test.sv
